// ===== src/mbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_pkg: shared constants, types and helpers
// Fixed-point scaling, divider step count, control/status bundles and the
// neutral-mode dither pattern table used by the brake/duty dither unit.
// ----------------------------------------------------------------------------
package mbd_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int SPEED_W   = 16;
    localparam int BRAKE_W   = FRAC_BITS + 1;

    // dither pattern selection
    localparam int SLOT_W    = 3;
    localparam int LEVEL_W   = 4;

    // restoring divider: one quotient bit per step, quotient is at most ONE
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // duty counts as near zero when |duty| * 10000 < ONE
    localparam int NEAR_MAX  = (ONE - 1) / 10000;

    localparam logic signed [SPEED_W-1:0] SPEED_ONE = SPEED_W'(ONE);
    localparam logic signed [SPEED_W-1:0] SPEED_NEAR = SPEED_W'(NEAR_MAX);

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } mbd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } mbd_status_t;

    // clamp a speed or duty to [-ONE, ONE]
    function automatic logic signed [SPEED_W-1:0] sat_speed(
        input logic signed [SPEED_W-1:0] v
    );
        logic signed [SPEED_W-1:0] res;
        if (v > SPEED_ONE)
            res = SPEED_ONE;
        else if (v < -SPEED_ONE)
            res = -SPEED_ONE;
        else
            res = v;
        return res;
    endfunction

    // nine-level dither pattern, one bit per slot
    function automatic logic [7:0] dither_pattern(input logic [LEVEL_W-1:0] level);
        logic [7:0] pat;
        case (level)
            4'd0:    pat = 8'h00;
            4'd1:    pat = 8'h01;
            4'd2:    pat = 8'h11;
            4'd3:    pat = 8'h25;
            4'd4:    pat = 8'h55;
            4'd5:    pat = 8'hD5;
            4'd6:    pat = 8'hEE;
            4'd7:    pat = 8'hFE;
            default: pat = 8'hFF;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

// ===== src/mbd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_ctrl: sequencing controller
// Accepts one tick, runs the shared divider for its fixed step count, then
// waits for the output register to be free before committing the result.
// ----------------------------------------------------------------------------
module mbd_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  mbd_pkg::mbd_status_t status,
    output mbd_pkg::mbd_cmd_t    cmd
);
    import mbd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/mbd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_datapath: speed mirroring, serial divider, dither state and output
// Classifies the tick on load, forms the quotient one bit per step, builds duty
// and brake, fills the output register and steps the dither slot on near-zero duty.
// ----------------------------------------------------------------------------
module mbd_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire  [31:0]          s_axis_tdata,  // [15:0] requested_speed, [31:16] measured_speed
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // [15:0] drive_duty, [30:16] brake_fraction,
                                                // [31] brake_mode
    input  mbd_pkg::mbd_cmd_t    cmd,
    output mbd_pkg::mbd_status_t status
);
    import mbd_pkg::*;

    localparam logic [1:0] KIND_PASS  = 2'd0;
    localparam logic [1:0] KIND_BRAKE = 2'd1;
    localparam logic [1:0] KIND_REV   = 2'd2;

    localparam logic [SPEED_W-1:0] DIV_ONE = SPEED_W'(ONE);

    // tick registers
    logic signed [SPEED_W-1:0] rr_reg;
    logic [1:0]                kind_reg;
    logic                      mirror_reg;
    logic [SPEED_W:0]          rem_reg;
    logic [SPEED_W-1:0]        dvsr_reg;
    logic [BRAKE_W-1:0]        quo_reg;

    // dither state and output
    logic [SLOT_W-1:0]         slot_reg;
    logic                      nb_reg;
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] duty_reg;
    logic [BRAKE_W-1:0]        brake_reg;

    // input saturation and mirroring
    logic signed [SPEED_W-1:0] r_sat, m_sat, rr, mm;
    logic signed [SPEED_W:0]   diff;
    logic                      mirror;
    logic [1:0]                kind;
    logic [SPEED_W-1:0]        dvsr;

    always_comb
    begin
        r_sat  = sat_speed(s_axis_tdata[15:0]);
        m_sat  = sat_speed(s_axis_tdata[31:16]);
        mirror = m_sat[SPEED_W-1];
        rr     = mirror ? -r_sat : r_sat;
        mm     = mirror ? -m_sat : m_sat;
        diff   = {mm[SPEED_W-1], mm} - {rr[SPEED_W-1], rr};
        if (rr >= mm)
            kind = KIND_PASS;
        else if (!rr[SPEED_W-1])
            kind = KIND_BRAKE;
        else
            kind = KIND_REV;
        dvsr = rr[SPEED_W-1] ? ($unsigned(mm) + DIV_ONE) : $unsigned(mm);
    end

    // one restoring division step
    logic             rem_ge;
    logic [SPEED_W:0] rem_sel;

    always_comb
    begin
        rem_ge  = rem_reg >= {1'b0, dvsr_reg};
        rem_sel = rem_ge ? (rem_reg - {1'b0, dvsr_reg}) : rem_reg;
    end

    // result forming and dither lookup
    logic signed [SPEED_W-1:0] quo_s, duty_calc, duty_fin;
    logic [BRAKE_W-1:0]        brake_calc;
    logic                      near_zero;
    logic [SLOT_W-1:0]         slot_inc;
    logic [LEVEL_W-1:0]        level;
    logic [7:0]                pattern;

    always_comb
    begin
        quo_s      = SPEED_W'(quo_reg);
        duty_calc  = '0;
        brake_calc = '0;
        case (kind_reg)
            KIND_PASS:
            begin
                duty_calc = rr_reg;
            end
            KIND_BRAKE:
            begin
                brake_calc = (rr_reg == '0) ? BRAKE_W'(ONE) : quo_reg;
            end
            default:
            begin
                duty_calc = -quo_s;
            end
        endcase
        duty_fin  = sat_speed(mirror_reg ? -duty_calc : duty_calc);
        near_zero = (duty_fin <= SPEED_NEAR) && (duty_fin >= -SPEED_NEAR);
        slot_inc  = slot_reg + 1'b1;
        level     = brake_calc[FRAC_BITS -: LEVEL_W];
        pattern   = dither_pattern(level);
    end

    // tick and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rr_reg     <= rr;
            kind_reg   <= kind;
            mirror_reg <= mirror;
            rem_reg    <= {1'b0, diff[SPEED_W-1:0]};
            dvsr_reg   <= dvsr;
            quo_reg    <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= {rem_sel[SPEED_W-1:0], 1'b0};
            quo_reg <= {quo_reg[BRAKE_W-2:0], rem_ge};
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            duty_reg  <= duty_fin;
            brake_reg <= brake_calc;
        end
    end

    // dither state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            nb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish && near_zero)
            begin
                slot_reg <= slot_inc;
                nb_reg   <= pattern[slot_inc];
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {nb_reg, brake_reg, duty_reg};

endmodule
`default_nettype wire

// ===== src/motor_brake_duty_dither_unit.sv =====
// An input transaction runs 15 divider steps, then the commit sets output valid.
// Ticks never overlap: the shared one-bit-per-cycle divider takes one tick at a time.
// A new tick is taken while a finished result still waits in the output register.
// Reset: dither slot 0, coast mode held, output register empty, controller idle.
`default_nettype none
// ----------------------------------------------------------------------------
// motor_brake_duty_dither_unit: motor brake/duty calculator with neutral dither
// Turns requested and measured speed into drive duty and brake fraction, and
// dithers the held neutral mode between brake and coast when duty is near zero.
// ----------------------------------------------------------------------------
module motor_brake_duty_dither_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // [15:0] requested_speed, [31:16] measured_speed
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // [15:0] drive_duty, [30:16] brake_fraction,
                                       // [31] brake_mode
);
    import mbd_pkg::*;

    mbd_cmd_t    cmd;
    mbd_status_t status;

    // sequencing
    mbd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // arithmetic and state
    mbd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .status        (status)
    );

    // a transaction starts a divide, so no second tick is taken next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a tick is in progress");

    // commit only when the output register can take the result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result committed over an untaken output");

    // braking and driving never coexist
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:16] == '0 || m_axis_tdata[15:0] == '0))
        else $error("nonzero duty with nonzero brake fraction");

    // brake fraction never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:16] <= BRAKE_W'(ONE)))
        else $error("brake fraction above one");

endmodule
`default_nettype wire
